### rtl/trp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_pkg
// Types and constants shared by the reply parser and its body decode.
// ----------------------------------------------------------------------------
package trp_pkg;

  // header layout
  localparam int HDR_LEN      = 5;
  localparam int COUNT_W      = 17;
  localparam int COUNT_MAX    = 65540;
  localparam int HEAD_MIN     = 10;

  localparam logic [COUNT_W-1:0] POS_CONN_LO = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] POS_CONN_HI = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] POS_SEQ     = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] POS_CMD     = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] POS_STATUS  = COUNT_W'(4);

  // body offsets used by the decode
  localparam int OFS_WORD0 = 0;
  localparam int OFS_WORD1 = 2;
  localparam int OFS_SIZE_LO = 6;
  localparam int OFS_SIZE_HI = 8;

  // minimum body lengths per reply kind
  localparam logic [COUNT_W-1:0] MIN_WORD   = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] MIN_MOUNT  = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] MIN_BYTE   = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] MIN_STAT   = COUNT_W'(10);

  // configuration port
  localparam int CFG_DATA_W = 8;
  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_EXPECTED_SEQ = 3'd0;
  localparam cfg_idx_t CFG_EXPECTED_CMD = 3'd1;
  localparam cfg_idx_t CFG_REPLY_KIND   = 3'd2;
  localparam cfg_idx_t CFG_OK_CODE      = 3'd3;
  localparam cfg_idx_t CFG_AGAIN_CODE   = 3'd4;

  localparam logic [7:0] AGAIN_RESET = 8'd7;

  // reply kinds
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_MOUNT   = 3'd1;
  localparam logic [2:0] KIND_HANDLE  = 3'd2;
  localparam logic [2:0] KIND_WRITE   = 3'd3;
  localparam logic [2:0] KIND_READ    = 3'd4;
  localparam logic [2:0] KIND_READDIR = 3'd5;
  localparam logic [2:0] KIND_STAT    = 3'd6;

  // finished datagram, handed from the byte collector to the decode
  typedef struct packed {
    logic [COUNT_W-1:0]           count;
    logic [15:0]                  conn;
    logic                         match;
    logic [7:0]                   status;
    logic [HEAD_MIN-1:0][7:0]     head;
    logic                         nul;
    logic [2:0]                   kind;
    logic [7:0]                   ok_code;
    logic [7:0]                   again_code;
  } snap_t;

  // one result transaction
  typedef struct packed {
    logic        header_ok;
    logic [15:0] conn_id;
    logic [7:0]  status_code;
    logic [15:0] retry_delay;
    logic [15:0] body_length;
    logic        body_ok;
    logic [31:0] value_a;
    logic [15:0] value_b;
  } result_t;

endpackage

### rtl/trp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_rx_if / trp_tx_if
// Valid/ready channels for datagram bytes in and parsed results out.
// ----------------------------------------------------------------------------
interface trp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       last_byte;

  modport source (output valid, rx_byte, last_byte, input ready);
  modport sink   (input valid, rx_byte, last_byte, output ready);
endinterface

interface trp_tx_if;
  logic        valid;
  logic        ready;
  logic        header_ok;
  logic [15:0] conn_id;
  logic [7:0]  status_code;
  logic [15:0] retry_delay;
  logic [15:0] body_length;
  logic        body_ok;
  logic [31:0] value_a;
  logic [15:0] value_b;

  modport source (output valid, header_ok, conn_id, status_code, retry_delay,
                  body_length, body_ok, value_a, value_b, input ready);
  modport sink   (input valid, header_ok, conn_id, status_code, retry_delay,
                  body_length, body_ok, value_a, value_b, output ready);
endinterface

### rtl/trp_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_decode
// Header check and kind-specific body decode of one finished datagram.
// ----------------------------------------------------------------------------
module trp_decode (
  input  trp_pkg::snap_t   snap,
  output trp_pkg::result_t res
);
  import trp_pkg::*;

  logic               hok;
  logic [COUNT_W-1:0] blen;
  logic [15:0]        word0;
  logic [15:0]        word1;
  logic [31:0]        size;
  logic               bok;
  logic [31:0]        va;
  logic [15:0]        vb;

  // body words, little-endian
  assign word0 = {snap.head[OFS_WORD0+1], snap.head[OFS_WORD0]};
  assign word1 = {snap.head[OFS_WORD1+1], snap.head[OFS_WORD1]};
  assign size  = {snap.head[OFS_SIZE_HI+1], snap.head[OFS_SIZE_HI],
                  snap.head[OFS_SIZE_LO+1], snap.head[OFS_SIZE_LO]};

  assign hok  = (snap.count >= COUNT_W'(HDR_LEN)) && snap.match;
  assign blen = snap.count - COUNT_W'(HDR_LEN);

  // kind-specific check and values
  always_comb begin
    bok = 1'b0;
    va  = '0;
    vb  = '0;
    if (snap.status == snap.ok_code) begin
      case (snap.kind)
        KIND_MOUNT: begin
          bok = blen >= MIN_MOUNT;
          va  = {16'd0, word0};
          vb  = word1;
        end
        KIND_HANDLE: begin
          bok = blen >= MIN_BYTE;
          va  = {24'd0, snap.head[OFS_WORD0]};
        end
        KIND_WRITE: begin
          bok = blen >= MIN_WORD;
          va  = {16'd0, word0};
        end
        KIND_READ: begin
          bok = (blen >= MIN_WORD) && ((COUNT_W'(word0) + MIN_WORD) <= blen);
          va  = {16'd0, word0};
        end
        KIND_READDIR: begin
          bok = (blen >= MIN_BYTE) && snap.nul;
        end
        KIND_STAT: begin
          bok = blen >= MIN_STAT;
          va  = size;
        end
        default: begin
          bok = 1'b1;
        end
      endcase
    end
  end

  // bad header zeroes everything, failed check zeroes the values
  always_comb begin
    res = '0;
    if (hok) begin
      res.header_ok   = 1'b1;
      res.conn_id     = snap.conn;
      res.status_code = snap.status;
      res.retry_delay = ((snap.status == snap.again_code) && (blen >= MIN_WORD))
                        ? word0 : 16'd0;
      res.body_length = blen[15:0];
      res.body_ok     = bok;
      res.value_a     = bok ? va : 32'd0;
      res.value_b     = bok ? vb : 16'd0;
    end
  end

endmodule

### rtl/tnfs_reply_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnfs_reply_parser
// Parses a reply datagram, one byte per transaction, into one result.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one datagram byte per transaction, last_byte set on the final
//   byte. The first byte of the next datagram may follow right behind it.
//   After the last byte one transaction appears on tx: the header fields,
//   the saturated body length and the decode chosen by reply_kind.
//   The taken last byte is captured in the snapshot stage; its decode then
//   moves into the result register that drives tx.
//   Throughput is one byte per cycle while rx.ready is high.
//   The configuration port writes one register per cycle with cfg_we; write
//   only between datagrams. Indexes past the register list are ignored.
//   A stalled tx holds its result; the snapshot stage behind it still takes
//   one more finished datagram before rx.ready drops.
//   Synchronous reset clears the datagram state, empties both stages and
//   loads the register defaults.
// ----------------------------------------------------------------------------
module tnfs_reply_parser #(
  parameter int HEAD_BYTES = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  trp_pkg::cfg_idx_t               cfg_index,
  input  logic [trp_pkg::CFG_DATA_W-1:0]  cfg_data,
  trp_rx_if.sink                          rx,
  trp_tx_if.source                        tx
);
  import trp_pkg::*;

  // configuration registers
  logic [7:0] expected_seq;
  logic [7:0] expected_cmd;
  logic [2:0] reply_kind;
  logic [7:0] ok_code;
  logic [7:0] again_code;

  // datagram state
  logic [COUNT_W-1:0] byte_count;
  logic [15:0]        conn_reg;
  logic               header_match;
  logic [7:0]         status_reg;
  logic [7:0]         body_head [HEAD_BYTES];
  logic               nul_seen;

  logic [COUNT_W-1:0] byte_count_next;
  logic [15:0]        conn_reg_next;
  logic               header_match_next;
  logic [7:0]         status_reg_next;
  logic [7:0]         body_head_next [HEAD_BYTES];
  logic               nul_seen_next;

  logic               in_body;
  logic [COUNT_W-1:0] body_idx;

  // pipeline
  snap_t   snap;
  snap_t   snap_next;
  logic    snap_valid;
  result_t res;
  result_t res_reg;
  logic    out_valid;
  logic    out_free;
  logic    snap_free;
  logic    take;

  assign out_free  = !out_valid || tx.ready;
  assign snap_free = !snap_valid || out_free;
  assign rx.ready  = snap_free;
  assign take      = rx.valid && snap_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_seq <= '0;
      expected_cmd <= '0;
      reply_kind   <= KIND_NONE;
      ok_code      <= '0;
      again_code   <= AGAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED_SEQ: expected_seq <= cfg_data[7:0];
        CFG_EXPECTED_CMD: expected_cmd <= cfg_data[7:0];
        CFG_REPLY_KIND:   reply_kind   <= cfg_data[2:0];
        CFG_OK_CODE:      ok_code      <= cfg_data[7:0];
        CFG_AGAIN_CODE:   again_code   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // byte position decode
  assign in_body  = byte_count >= COUNT_W'(HDR_LEN);
  assign body_idx = byte_count - COUNT_W'(HDR_LEN);

  always_comb begin
    conn_reg_next     = conn_reg;
    header_match_next = header_match;
    status_reg_next   = status_reg;
    nul_seen_next     = nul_seen;
    case (byte_count)
      POS_CONN_LO: conn_reg_next = {8'd0, rx.rx_byte};
      POS_CONN_HI: conn_reg_next = {rx.rx_byte, conn_reg[7:0]};
      POS_SEQ:     if (rx.rx_byte != expected_seq) header_match_next = 1'b0;
      POS_CMD:     if (rx.rx_byte != expected_cmd) header_match_next = 1'b0;
      POS_STATUS:  status_reg_next = rx.rx_byte;
      default:     if (rx.rx_byte == 8'd0) nul_seen_next = 1'b1;
    endcase
    byte_count_next = (byte_count < COUNT_W'(COUNT_MAX))
                      ? byte_count + COUNT_W'(1) : byte_count;
  end

  // first body bytes kept
  always_comb begin
    for (int i = 0; i < HEAD_BYTES; i++) begin
      body_head_next[i] = (in_body && (body_idx == COUNT_W'(i)))
                          ? rx.rx_byte : body_head[i];
    end
  end

  // finished datagram as seen after its last byte
  always_comb begin
    snap_next.count      = byte_count_next;
    snap_next.conn       = conn_reg_next;
    snap_next.match      = header_match_next;
    snap_next.status     = status_reg_next;
    for (int i = 0; i < HEAD_MIN; i++) begin
      snap_next.head[i] = body_head_next[i];
    end
    snap_next.nul        = nul_seen_next;
    snap_next.kind       = reply_kind;
    snap_next.ok_code    = ok_code;
    snap_next.again_code = again_code;
  end

  // datagram state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst || (take && rx.last_byte)) begin
      byte_count   <= '0;
      conn_reg     <= '0;
      header_match <= 1'b1;
      status_reg   <= '0;
      nul_seen     <= 1'b0;
      for (int i = 0; i < HEAD_BYTES; i++) body_head[i] <= '0;
    end else if (take) begin
      byte_count   <= byte_count_next;
      conn_reg     <= conn_reg_next;
      header_match <= header_match_next;
      status_reg   <= status_reg_next;
      nul_seen     <= nul_seen_next;
      for (int i = 0; i < HEAD_BYTES; i++) body_head[i] <= body_head_next[i];
    end
  end

  // snapshot stage
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (take && rx.last_byte) begin
      snap_valid <= 1'b1;
    end else if (out_free) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && rx.last_byte) snap <= snap_next;
  end

  trp_decode u_decode (
    .snap (snap),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && snap_valid) res_reg <= res;
  end

  assign tx.valid       = out_valid;
  assign tx.header_ok   = res_reg.header_ok;
  assign tx.conn_id     = res_reg.conn_id;
  assign tx.status_code = res_reg.status_code;
  assign tx.retry_delay = res_reg.retry_delay;
  assign tx.body_length = res_reg.body_length;
  assign tx.body_ok     = res_reg.body_ok;
  assign tx.value_a     = res_reg.value_a;
  assign tx.value_b     = res_reg.value_b;

endmodule

### rtl/trp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trp_checker
// Port-level checks on the reply parser result channel, bound to the top.
// ----------------------------------------------------------------------------
module trp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        header_ok,
  input logic [15:0] conn_id,
  input logic [7:0]  status_code,
  input logic [15:0] retry_delay,
  input logic [15:0] body_length,
  input logic        body_ok,
  input logic [31:0] value_a,
  input logic [15:0] value_b
);

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // stalled result stays valid and holds conn_id, value_a, body_ok and body_length
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(conn_id) && $stable(value_a)
      && $stable(body_ok) && $stable(body_length))
    else $error("stalled result changed");

  // bad header clears conn_id, status code, retry delay, body length and body ok
  a_bad_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && !header_ok |-> conn_id == 16'd0 && status_code == 8'd0
      && retry_delay == 16'd0 && body_length == 16'd0 && !body_ok)
    else $error("fields set with bad header");

  // failed body check clears the values
  a_bad_body: assert property (@(posedge clk) disable iff (rst)
    out_valid && !body_ok |-> value_a == 32'd0 && value_b == 16'd0)
    else $error("values set with failed body check");

  // body ok needs a good header
  a_body_needs_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && body_ok |-> header_ok)
    else $error("body ok without header ok");

endmodule

bind tnfs_reply_parser trp_checker u_trp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (tx.valid),
  .out_ready   (tx.ready),
  .header_ok   (tx.header_ok),
  .conn_id     (tx.conn_id),
  .status_code (tx.status_code),
  .retry_delay (tx.retry_delay),
  .body_length (tx.body_length),
  .body_ok     (tx.body_ok),
  .value_a     (tx.value_a),
  .value_b     (tx.value_b)
);
